### sv/grag_pkg.sv
package grag_pkg;

    localparam int SIDE_W   = 8;
    localparam int MAX_SIDE = 255;
    localparam int ALIGN_W  = 7;
    localparam int STRIDE_W = 9;
    localparam int OFFSET_W = 17;
    localparam int PIXEL_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [1:0] {
        ROT_NORMAL = 2'd0,
        ROT_RIGHT  = 2'd1,
        ROT_FLIP   = 2'd2,
        ROT_LEFT   = 2'd3
    } rot_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROTATION   = 2'd0,
        CFG_SRC_WIDTH  = 2'd1,
        CFG_SRC_HEIGHT = 2'd2,
        CFG_ROW_ALIGN  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        rot_t                rotation;
        logic [SIDE_W-1:0]   width;
        logic [SIDE_W-1:0]   height;
        logic [STRIDE_W-1:0] stride;
    } geom_t;

    localparam int RST_WIDTH  = 8;
    localparam int RST_HEIGHT = 16;
    localparam int RST_ALIGN  = 1;
    localparam int RST_STRIDE = RST_ALIGN * ((RST_WIDTH + RST_ALIGN - 1) / RST_ALIGN);

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] res;
        if (v == '0)
        begin
            res = SIDE_W'(1);
        end
        else if (int'(v) > MAX_SIDE)
        begin
            res = SIDE_W'(MAX_SIDE);
        end
        else
        begin
            res = v;
        end
        return res;
    endfunction

endpackage

### sv/glyph_rotate_address_gen.sv
// Glyph rotation address generator. Source pixels arrive one per transaction in raster
// order; each leaves with its byte offset in the rotated buffer, the rotated width,
// height and stride, and glyph_done on the glyph's last pixel. Throughput is one
// pixel per cycle while in_stall is low; a pixel goes through the input register, then
// the multiply-add into the output register. Any configuration write restarts the glyph
// and starts the stride unit, a bit-serial remainder that holds in_stall high while busy.
module glyph_rotate_address_gen
    import grag_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [PIXEL_W-1:0]    pixel_in,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [PIXEL_W-1:0]    pixel_out,
    output logic [OFFSET_W-1:0]   dest_offset,
    output logic                  glyph_done,
    output logic [SIDE_W-1:0]     out_width,
    output logic [SIDE_W-1:0]     out_height,
    output logic [STRIDE_W-1:0]   out_stride
);

    rot_t               rot_reg, rot_next;
    logic [SIDE_W-1:0]  src_w_reg, src_w_next;
    logic [SIDE_W-1:0]  src_h_reg, src_h_next;
    logic [ALIGN_W-1:0] align_reg, align_next;
    logic [SIDE_W-1:0]  row_reg, row_next;
    logic [SIDE_W-1:0]  col_reg, col_next;

    logic [SIDE_W-1:0]   eff_w_val;
    logic [SIDE_W-1:0]   eff_h_val;
    logic [SIDE_W-1:0]   ow_new;
    logic [ALIGN_W-1:0]  align_new;
    logic                busy;
    logic                hold;
    logic                accept;
    logic [STRIDE_W-1:0] stride;
    geom_t               geom;

    assign eff_w_val = clamp_side(src_w_reg);
    assign eff_h_val = clamp_side(src_h_reg);
    assign in_stall  = busy || hold;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        rot_next   = rot_reg;
        src_w_next = src_w_reg;
        src_h_next = src_h_reg;
        align_next = align_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ROTATION:   rot_next   = rot_t'(cfg_data[1:0]);
                CFG_SRC_WIDTH:  src_w_next = cfg_data;
                CFG_SRC_HEIGHT: src_h_next = cfg_data;
                CFG_ROW_ALIGN:  align_next = cfg_data[ALIGN_W-1:0];
                default:        rot_next   = rot_reg;
            endcase
        end
        ow_new    = rot_next[0] ? clamp_side(src_h_next) : clamp_side(src_w_next);
        align_new = (align_next == '0) ? ALIGN_W'(1) : align_next;
    end

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (cfg_write_en)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (accept)
        begin
            if (col_reg + 8'd1 >= eff_w_val)
            begin
                col_next = '0;
                row_next = (row_reg + 8'd1 >= eff_h_val) ? '0 : row_reg + 8'd1;
            end
            else
            begin
                col_next = col_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg   <= ROT_NORMAL;
            src_w_reg <= SIDE_W'(RST_WIDTH);
            src_h_reg <= SIDE_W'(RST_HEIGHT);
            align_reg <= ALIGN_W'(RST_ALIGN);
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else
        begin
            rot_reg   <= rot_next;
            src_w_reg <= src_w_next;
            src_h_reg <= src_h_next;
            align_reg <= align_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

    grag_stride u_stride (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cfg_write_en),
        .ow     (ow_new),
        .align  (align_new),
        .busy   (busy),
        .stride (stride)
    );

    always_comb
    begin
        geom.rotation = rot_reg;
        geom.width    = eff_w_val;
        geom.height   = eff_h_val;
        geom.stride   = stride;
    end

    grag_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .geom        (geom),
        .accept      (accept),
        .pixel       (pixel_in),
        .row         (row_reg),
        .col         (col_reg),
        .out_stall   (out_stall),
        .hold        (hold),
        .out_valid   (out_valid),
        .pixel_out   (pixel_out),
        .dest_offset (dest_offset),
        .glyph_done  (glyph_done),
        .out_width   (out_width),
        .out_height  (out_height),
        .out_stride  (out_stride)
    );

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> in_stall)
        else $error("input taken while stride unit busy");

    a_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write_en |=> (row_reg == '0) && (col_reg == '0))
        else $error("counters not cleared by register write");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg < eff_w_val) && (row_reg < eff_h_val))
        else $error("position counter out of glyph");

    a_offset_in_buffer: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (dest_offset < OFFSET_W'(out_stride) * OFFSET_W'(out_height)))
        else $error("offset beyond rotated buffer");

endmodule

### sv/grag_stride.sv
module grag_stride
    import grag_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [SIDE_W-1:0]   ow,
    input  logic [ALIGN_W-1:0]  align,
    output logic                busy,
    output logic [STRIDE_W-1:0] stride
);

    // restoring remainder, one bit of ow per cycle
    logic                busy_reg, busy_next;
    logic [2:0]          cnt_reg, cnt_next;
    logic [SIDE_W-1:0]   rem_reg, rem_next;
    logic [SIDE_W-1:0]   ow_reg, ow_next;
    logic [ALIGN_W-1:0]  align_reg, align_next;
    logic [STRIDE_W-1:0] stride_reg, stride_next;
    logic [SIDE_W-1:0]   trial;
    logic [SIDE_W-1:0]   rem_step;

    always_comb
    begin
        trial    = {rem_reg[SIDE_W-2:0], ow_reg[cnt_reg]};
        rem_step = (trial >= {1'b0, align_reg}) ? trial - {1'b0, align_reg} : trial;
    end

    always_comb
    begin
        busy_next   = busy_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        ow_next     = ow_reg;
        align_next  = align_reg;
        stride_next = stride_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = 3'd7;
            rem_next   = '0;
            ow_next    = ow;
            align_next = align;
        end
        else if (busy_reg)
        begin
            rem_next = rem_step;
            cnt_next = cnt_reg - 3'd1;
            if (cnt_reg == 3'd0)
            begin
                busy_next = 1'b0;
                if (rem_step == '0)
                begin
                    stride_next = {1'b0, ow_reg};
                end
                else
                begin
                    stride_next = {1'b0, ow_reg} + {2'b0, align_reg} - {1'b0, rem_step};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            cnt_reg    <= '0;
            stride_reg <= STRIDE_W'(RST_STRIDE);
        end
        else
        begin
            busy_reg   <= busy_next;
            cnt_reg    <= cnt_next;
            stride_reg <= stride_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        ow_reg    <= ow_next;
        align_reg <= align_next;
    end

    assign busy   = busy_reg;
    assign stride = stride_reg;

endmodule

### sv/grag_datapath.sv
module grag_datapath
    import grag_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  geom_t               geom,
    input  logic                accept,
    input  logic [PIXEL_W-1:0]  pixel,
    input  logic [SIDE_W-1:0]   row,
    input  logic [SIDE_W-1:0]   col,
    input  logic                out_stall,
    output logic                hold,
    output logic                out_valid,
    output logic [PIXEL_W-1:0]  pixel_out,
    output logic [OFFSET_W-1:0] dest_offset,
    output logic                glyph_done,
    output logic [SIDE_W-1:0]   out_width,
    output logic [SIDE_W-1:0]   out_height,
    output logic [STRIDE_W-1:0] out_stride
);

    logic                s1_valid_reg, s1_valid_next;
    logic [PIXEL_W-1:0]  s1_pixel_reg;
    logic [SIDE_W-1:0]   s1_row_reg;
    logic [SIDE_W-1:0]   s1_col_reg;

    logic                out_valid_reg, out_valid_next;
    logic [PIXEL_W-1:0]  pixel_reg;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic                done_reg, done_next;
    logic [SIDE_W-1:0]   width_reg, width_next;
    logic [SIDE_W-1:0]   height_reg, height_next;
    logic [STRIDE_W-1:0] stride_reg;

    logic                advance;
    logic [SIDE_W-1:0]   row_rev;
    logic [SIDE_W-1:0]   col_rev;
    logic [SIDE_W-1:0]   mul_a;
    logic [SIDE_W-1:0]   add_b;

    assign advance = !out_valid_reg || !out_stall;
    assign hold    = s1_valid_reg && !advance;

    always_comb
    begin
        s1_valid_next  = accept || (s1_valid_reg && !advance);
        out_valid_next = advance ? s1_valid_reg : out_valid_reg;
    end

    always_comb
    begin
        row_rev = geom.height - 8'd1 - s1_row_reg;
        col_rev = geom.width - 8'd1 - s1_col_reg;
        case (geom.rotation)
            ROT_NORMAL:
            begin
                mul_a = s1_row_reg;
                add_b = s1_col_reg;
            end
            ROT_RIGHT:
            begin
                mul_a = s1_col_reg;
                add_b = row_rev;
            end
            ROT_FLIP:
            begin
                mul_a = row_rev;
                add_b = col_rev;
            end
            default:
            begin
                mul_a = col_rev;
                add_b = s1_row_reg;
            end
        endcase
        offset_next = OFFSET_W'(mul_a) * OFFSET_W'(geom.stride) + OFFSET_W'(add_b);
        done_next   = (s1_row_reg == geom.height - 8'd1) && (s1_col_reg == geom.width - 8'd1);
        width_next  = geom.rotation[0] ? geom.height : geom.width;
        height_next = geom.rotation[0] ? geom.width : geom.height;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= pixel;
            s1_row_reg   <= row;
            s1_col_reg   <= col;
        end
        if (advance && s1_valid_reg)
        begin
            pixel_reg  <= s1_pixel_reg;
            offset_reg <= offset_next;
            done_reg   <= done_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            stride_reg <= geom.stride;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_out   = pixel_reg;
    assign dest_offset = offset_reg;
    assign glyph_done  = done_reg;
    assign out_width   = width_reg;
    assign out_height  = height_reg;
    assign out_stride  = stride_reg;

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import grag_pkg::*;

    localparam int RANDOM_ITEMS  = 1250;
    localparam int SETTLE_CYCLES = 12;
    localparam int IDLE_LIMIT    = 2000;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [PIXEL_W-1:0]  pixel;
        logic [OFFSET_W-1:0] offset;
        logic                done;
        logic [SIDE_W-1:0]   width;
        logic [SIDE_W-1:0]   height;
        logic [STRIDE_W-1:0] stride;
    } placement_t;

    typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        cfg_idx_t              index;
        logic [CFG_DATA_W-1:0] data;
        logic                  typed;
        placement_t            want;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [PIXEL_W-1:0]    pixel_in;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [PIXEL_W-1:0]    pixel_out;
    logic [OFFSET_W-1:0]   dest_offset;
    logic                  glyph_done;
    logic [SIDE_W-1:0]     out_width;
    logic [SIDE_W-1:0]     out_height;
    logic [STRIDE_W-1:0]   out_stride;

    placement_t placement_q[$];
    dir_row_t   directed_rows[$];

    rot_t        cur_rot;
    logic [7:0]  reg_width;
    logic [7:0]  reg_height;
    logic [6:0]  reg_align;
    int          side_w;
    int          side_h;
    int          stride_bytes;
    int          row_pos;
    int          col_pos;

    int mismatches;
    int pixels_sent;
    int random_pixels;
    int results_seen;
    int glyphs_done;
    int reg_writes;
    int idle_cycles;
    int stall_left;
    bit no_gaps;

    glyph_rotate_address_gen uut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void update_geometry();
        int a;
        int ow;
        a = (reg_align == '0) ? 1 : int'(reg_align);
        side_w = (reg_width == '0) ? 1 : ((int'(reg_width) > MAX_SIDE) ? MAX_SIDE : int'(reg_width));
        side_h = (reg_height == '0) ? 1
               : ((int'(reg_height) > MAX_SIDE) ? MAX_SIDE : int'(reg_height));
        ow = (cur_rot == ROT_NORMAL || cur_rot == ROT_FLIP) ? side_w : side_h;
        stride_bytes = a * ((ow + a - 1) / a);
        row_pos = 0;
        col_pos = 0;
    endfunction

    function automatic void write_geometry_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_ROTATION:   cur_rot = rot_t'(val[1:0]);
            CFG_SRC_WIDTH:  reg_width = val;
            CFG_SRC_HEIGHT: reg_height = val;
            CFG_ROW_ALIGN:  reg_align = val[6:0];
        endcase
        update_geometry();
    endfunction

    function automatic placement_t place_pixel(logic [PIXEL_W-1:0] px);
        placement_t p;
        int off;
        int ow;
        int oh;
        case (cur_rot)
            ROT_NORMAL:
            begin
                off = row_pos * stride_bytes + col_pos;
                ow = side_w;
                oh = side_h;
            end
            ROT_RIGHT:
            begin
                off = col_pos * stride_bytes + (side_h - 1 - row_pos);
                ow = side_h;
                oh = side_w;
            end
            ROT_FLIP:
            begin
                off = (side_h - 1 - row_pos) * stride_bytes + (side_w - 1 - col_pos);
                ow = side_w;
                oh = side_h;
            end
            default:
            begin
                off = (side_w - 1 - col_pos) * stride_bytes + row_pos;
                ow = side_h;
                oh = side_w;
            end
        endcase
        p.pixel  = px;
        p.offset = OFFSET_W'(off);
        p.done   = (row_pos == side_h - 1) && (col_pos == side_w - 1);
        p.width  = SIDE_W'(ow);
        p.height = SIDE_W'(oh);
        p.stride = STRIDE_W'(stride_bytes);
        if (col_pos + 1 >= side_w)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= side_h) ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos = col_pos + 1;
        end
        return p;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_reg_value(cfg_idx_t idx);
        logic [CFG_DATA_W-1:0] v;
        case (idx)
            CFG_ROTATION:
            begin
                v = CFG_DATA_W'($urandom_range(0, 255));
            end
            CFG_ROW_ALIGN:
            begin
                case ($urandom_range(0, 7))
                    0:       v = '0;
                    1:       v = CFG_DATA_W'(64);
                    2, 3:    v = CFG_DATA_W'($urandom_range(0, 255));
                    default: v = CFG_DATA_W'($urandom_range(1, 8));
                endcase
            end
            default:
            begin
                case ($urandom_range(0, 9))
                    0:       v = '0;
                    1:       v = CFG_DATA_W'(255);
                    2:       v = CFG_DATA_W'($urandom_range(0, 255));
                    default: v = CFG_DATA_W'($urandom_range(1, 8));
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic void add_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        dir_row_t r;
        r = '0;
        r.kind  = ROW_CFG;
        r.index = idx;
        r.data  = val;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_pixel(logic [PIXEL_W-1:0] px);
        dir_row_t r;
        r = '0;
        r.kind = ROW_PIX;
        r.data = px;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_checked(logic [PIXEL_W-1:0] px, int off, bit done,
                                        int w, int h, int s);
        dir_row_t r;
        r = '0;
        r.kind        = ROW_PIX;
        r.data        = px;
        r.typed       = 1'b1;
        r.want.pixel  = px;
        r.want.offset = OFFSET_W'(off);
        r.want.done   = done;
        r.want.width  = SIDE_W'(w);
        r.want.height = SIDE_W'(h);
        r.want.stride = STRIDE_W'(s);
        directed_rows.push_back(r);
    endfunction

    task automatic send_pixel(input logic [PIXEL_W-1:0] px, input bit typed,
                              input placement_t fixed);
        placement_t predicted;
        int gap;
        gap = no_gaps ? 0 : int'($urandom_range(0, 6));
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_in <= px;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        predicted = place_pixel(px);
        placement_q.push_back(typed ? fixed : predicted);
        pixels_sent++;
    endtask

    // registers change only with the pipeline drained and the stride unit settled
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        in_valid <= 1'b0;
        while (placement_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        write_geometry_reg(idx, val);
        reg_writes++;
    endtask

    task automatic check_result();
        placement_t got;
        placement_t want;
        got = '{pixel_out, dest_offset, glyph_done, out_width, out_height, out_stride};
        results_seen++;
        if (got.done)
        begin
            glyphs_done++;
        end
        if (placement_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
            begin
                $display("unexpected transaction: pixel %h offset %0d", got.pixel, got.offset);
            end
        end
        else
        begin
            want = placement_q.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("mismatch (exp/act): pixel %h/%h offset %0d/%0d done %b/%b",
                             want.pixel, got.pixel, want.offset, got.offset,
                             want.done, got.done);
                    $display("    width %0d/%0d height %0d/%0d stride %0d/%0d",
                             want.width, got.width, want.height, got.height,
                             want.stride, got.stride);
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                check_result();
                stall_left = no_gaps ? 0 : int'($urandom_range(0, 6));
                if (stall_left > 0)
                begin
                    out_stall <= 1'b1;
                end
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                if (stall_left == 0)
                begin
                    out_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        dir_row_t row;
        int count;
        int area;
        cfg_idx_t idx;

        rst_n        = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        pixel_in     = '0;
        no_gaps      = 1'b0;

        cur_rot    = ROT_NORMAL;
        reg_width  = 8'(RST_WIDTH);
        reg_height = 8'(RST_HEIGHT);
        reg_align  = 7'(RST_ALIGN);
        update_geometry();

        // reset geometry: 8 x 16, stride 8
        add_checked(8'h00, 0, 1'b0, 8, 16, 8);
        add_checked(8'hFF, 1, 1'b0, 8, 16, 8);
        add_pixel(8'h80);
        // zero width and zero alignment, 1 x 3 turned left
        add_write(CFG_SRC_WIDTH, 8'd0);
        add_write(CFG_SRC_HEIGHT, 8'd3);
        add_write(CFG_ROTATION, {6'd0, ROT_LEFT});
        add_write(CFG_ROW_ALIGN, 8'd0);
        add_checked(8'hA5, 0, 1'b0, 3, 1, 3);
        add_checked(8'h5A, 1, 1'b0, 3, 1, 3);
        add_checked(8'h3C, 2, 1'b1, 3, 1, 3);
        add_checked(8'hC3, 0, 1'b0, 3, 1, 3);
        // largest glyph, alignment 127, upper data bits set
        add_write(CFG_ROTATION, {6'h3F, ROT_FLIP});
        add_write(CFG_SRC_WIDTH, 8'hFF);
        add_write(CFG_SRC_HEIGHT, 8'hFF);
        add_write(CFG_ROW_ALIGN, 8'hFF);
        add_checked(8'h01, 97028, 1'b0, 255, 255, 381);
        add_pixel(8'h02);
        add_write(CFG_ROTATION, {6'd0, ROT_RIGHT});
        add_write(CFG_SRC_HEIGHT, 8'd1);
        add_write(CFG_ROW_ALIGN, 8'd64);
        add_checked(8'h7E, 0, 1'b0, 1, 255, 64);
        add_pixel(8'h81);
        // restart in the middle of a glyph
        add_write(CFG_SRC_HEIGHT, 8'd2);
        add_pixel(8'h10);
        add_pixel(8'h20);
        add_write(CFG_ROTATION, {6'd0, ROT_NORMAL});
        add_write(CFG_SRC_WIDTH, 8'd70);
        add_write(CFG_ROW_ALIGN, 8'd65);
        add_pixel(8'h04);
        add_pixel(8'h08);
        add_pixel(8'h40);
        add_write(CFG_ROTATION, {6'd0, ROT_LEFT});
        add_pixel(8'hF0);
        add_pixel(8'h0F);
        // single pixel glyph: every pixel is the last one
        add_write(CFG_SRC_WIDTH, 8'd1);
        add_write(CFG_SRC_HEIGHT, 8'd1);
        add_write(CFG_ROTATION, {6'd0, ROT_FLIP});
        add_write(CFG_ROW_ALIGN, 8'd1);
        add_checked(8'h55, 0, 1'b1, 1, 1, 1);
        add_checked(8'hAA, 0, 1'b1, 1, 1, 1);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG)
            begin
                write_reg(row.index, row.data);
            end
            else
            begin
                send_pixel(row.data, row.typed, row.want);
            end
        end

        while (random_pixels < RANDOM_ITEMS)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 4))
            begin
                idx = cfg_idx_t'($urandom_range(0, 3));
                write_reg(idx, pick_reg_value(idx));
            end
            area = side_w * side_h;
            if (area <= 64)
            begin
                count = area * int'($urandom_range(1, 3)) + int'($urandom_range(0, area - 1));
            end
            else if (area <= 600)
            begin
                count = area + int'($urandom_range(0, 10));
            end
            else
            begin
                count = int'($urandom_range(1, 60));
            end
            if (count > RANDOM_ITEMS - random_pixels)
            begin
                count = RANDOM_ITEMS - random_pixels;
            end
            repeat (count) send_pixel(PIXEL_W'($urandom_range(0, 255)), 1'b0, '0);
            random_pixels += count;
        end

        in_valid <= 1'b0;
        while (placement_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("sent %0d pixels, checked %0d placements, %0d glyphs completed",
                 pixels_sent, results_seen, glyphs_done);
        $display("%0d register writes across all rotations, %0d mismatches",
                 reg_writes, mismatches);
        if (mismatches == 0)
        begin
            $display("tb_top: PASS");
        end
        else
        begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
